[rtl/nfia_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none

package nfia_pkg;

   // Geometry of one word of the used map.
   localparam int WORD_W = 32;
   localparam int BIT_W  = 5;

   // Field widths.
   localparam int ID_W     = 24;
   localparam int COUNT_W  = 9;
   localparam int STATUS_W = 2;
   localparam int CSR_IDX_W = 1;

   // Request kinds.
   localparam logic KIND_ALLOC = 1'b0;
   localparam logic KIND_FREE  = 1'b1;

   // Response status codes.
   localparam logic [STATUS_W-1:0] STATUS_DONE  = 2'd0;
   localparam logic [STATUS_W-1:0] STATUS_FULL  = 2'd1;
   localparam logic [STATUS_W-1:0] STATUS_RANGE = 2'd2;

   // Configuration register indexes.
   localparam logic [CSR_IDX_W-1:0] REG_INDEX_BASE  = 1'd0;
   localparam logic [CSR_IDX_W-1:0] REG_INDEX_COUNT = 1'd1;

   typedef enum logic [2:0] {
      S_CLEAR,
      S_IDLE,
      S_SCAN,
      S_FREE,
      S_DONE
   } state_type;

   typedef struct packed {
      logic             found;
      logic [BIT_W-1:0] pos;
   } bit_hit_type;

   // Lowest set bit of a map word.
   function automatic bit_hit_type first_set(input logic [WORD_W-1:0] vec);
      bit_hit_type hit;
      hit.found = 1'b0;
      hit.pos   = '0;
      for (int i = WORD_W - 1; i >= 0; i--) begin
         if (vec[i]) begin
            hit.found = 1'b1;
            hit.pos   = BIT_W'(i);
         end
      end
      return hit;
   endfunction

endpackage

`default_nettype wire

[rtl/nfia_if.sv]
`timescale 1ns / 1ps
`default_nettype none

// Request channel.
interface nfia_req_if import nfia_pkg::*; ();
   logic            valid;
   logic            ready;
   logic            kind;
   logic [ID_W-1:0] index;

   modport source (output valid, output kind, output index, input ready);
   modport sink   (input valid, input kind, input index, output ready);
endinterface

// Response channel.
interface nfia_rsp_if import nfia_pkg::*; ();
   logic                valid;
   logic                ready;
   logic [STATUS_W-1:0] status;
   logic [ID_W-1:0]     granted_index;

   modport source (output valid, output status, output granted_index, input ready);
   modport sink   (input valid, input status, input granted_index, output ready);
endinterface

`default_nettype wire

[rtl/next_fit_index_allocator_core.sv]
`timescale 1ns / 1ps
`default_nettype none

// Next-fit identifier allocator.
// A word on the req channel either asks for a new identifier (kind 0) or
// returns one (kind 1, identifier in index). Each request produces exactly
// one word on the rsp channel carrying a status and, for a successful
// allocate, the granted identifier. Slot s of the used map stands for
// identifier csr base + s; the csr count limits how many slots are live.
// The used map lives in a RAM of 32-bit words, W = ceil(SLOT_COUNT / 32).
// An allocate reads one map word per cycle starting at the word of the last
// granted slot, then wraps once to word 0, reading k words in all, with k
// between 1 and 2 * W (k is at most 8 for a full 256-slot map without the
// wrap, 16 with it). A free reads the word of the returned slot and writes
// it back with that bit cleared; a request rejected up front goes straight
// to the finishing state. The block handles one request at a time; req.ready
// rises as the response moves into the output register.
// After reset a clearing pass writes zero to every map word, during which
// no request is accepted; csr writes are always taken.
// If the receiver stalls, the response holds in the output register and a
// finished request waits in the sequencer, so no new request is taken.

module next_fit_index_allocator_core import nfia_pkg::*; #(
   parameter int SLOT_COUNT = 256
) (
   input  wire logic                 clock,
   input  wire logic                 reset,
   nfia_req_if.sink                  req,
   nfia_rsp_if.source                rsp,
   input  wire logic                 csr_wr_en,
   input  wire logic [CSR_IDX_W-1:0] csr_index,
   input  wire logic [ID_W-1:0]      csr_wr_data
);

   localparam int WORDS  = (SLOT_COUNT + WORD_W - 1) / WORD_W;
   localparam int AW     = (WORDS > 1) ? $clog2(WORDS) : 1;
   localparam int XW     = AW + BIT_W;                       // word and bit of a slot
   localparam int SW     = $clog2(SLOT_COUNT);               // stored slot number
   localparam int NW     = $clog2(SLOT_COUNT + 1);           // live slot count
   localparam int CW     = (NW > COUNT_W) ? NW : COUNT_W;    // count compare width

   state_type state_ff, state_in;

   logic [ID_W-1:0]     base_ff;
   logic [COUNT_W-1:0]  count_ff;
   logic [SW-1:0]       start_ff, start_in;
   logic [AW-1:0]       clr_ff, clr_in;
   logic [AW-1:0]       cur_ff, cur_in;
   logic                phase_ff, phase_in;
   logic [BIT_W-1:0]    bit_ff, bit_in;
   logic [STATUS_W-1:0] pend_status_ff, pend_status_in;
   logic [ID_W-1:0]     pend_granted_ff, pend_granted_in;
   logic                rsp_valid_ff, rsp_valid_in;
   logic [STATUS_W-1:0] rsp_status_ff, rsp_status_in;
   logic [ID_W-1:0]     rsp_granted_ff, rsp_granted_in;

   logic              ram_we;
   logic [AW-1:0]     ram_waddr;
   logic [WORD_W-1:0] ram_wdata;
   logic              ram_re;
   logic [AW-1:0]     ram_raddr;
   logic [WORD_W-1:0] ram_rdata;

   // The live slot count is the count register clamped to the number of built slots.
   logic [CW-1:0]     count_ext;
   logic [NW-1:0]     live_n;
   logic [XW-1:0]     last_slot;
   logic [AW-1:0]     last_word;
   logic [BIT_W-1:0]  last_bit;
   logic [XW-1:0]     start_slot;
   logic [AW-1:0]     start_word;
   logic [BIT_W-1:0]  start_bit;
   logic              start_live;
   logic [ID_W-1:0]   free_off;
   logic              free_live;
   logic [XW-1:0]     free_slot;
   logic [WORD_W-1:0] lo_mask, hi_mask, cand;
   bit_hit_type       hit;
   logic              out_free;

   assign count_ext  = CW'(count_ff);
   assign live_n     = (count_ext > CW'(SLOT_COUNT)) ? NW'(SLOT_COUNT) : NW'(count_ext);
   assign last_slot  = XW'(live_n - NW'(1));
   assign last_word  = last_slot[XW-1:BIT_W];
   assign last_bit   = last_slot[BIT_W-1:0];
   assign start_slot = XW'(start_ff);
   assign start_word = start_slot[XW-1:BIT_W];
   assign start_bit  = start_slot[BIT_W-1:0];
   assign start_live = NW'(start_ff) < live_n;

   // Offset of a returned identifier, modulo the identifier space.
   assign free_off  = req.index - base_ff;
   assign free_live = free_off < ID_W'(live_n);
   assign free_slot = XW'(free_off);

   // Candidate free bits of the word now on the RAM read port. The first
   // pass excludes slots below the search start, and both passes exclude
   // slots at or above the live count.
   always_comb begin
      lo_mask = '1;
      hi_mask = '1;
      if (!phase_ff && cur_ff == start_word) begin
         lo_mask = {WORD_W{1'b1}} << start_bit;
      end
      if (cur_ff == last_word) begin
         hi_mask = {WORD_W{1'b1}} >> (BIT_W'(WORD_W - 1) - last_bit);
      end
      cand = ~ram_rdata & lo_mask & hi_mask;
      hit  = first_set(cand);
   end

   assign out_free = !rsp_valid_ff || rsp.ready;

   assign req.ready         = (state_ff == S_IDLE);
   assign rsp.valid         = rsp_valid_ff;
   assign rsp.status        = rsp_status_ff;
   assign rsp.granted_index = rsp_granted_ff;

   nfia_ram #(
      .WIDTH (WORD_W),
      .DEPTH (WORDS)
   ) u_map (
      .clock   (clock),
      .wr_en   (ram_we),
      .wr_addr (ram_waddr),
      .wr_data (ram_wdata),
      .rd_en   (ram_re),
      .rd_addr (ram_raddr),
      .rd_data (ram_rdata)
   );

   // Configuration registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         base_ff  <= '0;
         count_ff <= COUNT_W'(256);
      end else if (csr_wr_en) begin
         unique case (csr_index)
            REG_INDEX_BASE:  base_ff  <= csr_wr_data;
            REG_INDEX_COUNT: count_ff <= csr_wr_data[COUNT_W-1:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_CLEAR;
         clr_ff       <= '0;
         start_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         clr_ff       <= clr_in;
         start_ff     <= start_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      cur_ff          <= cur_in;
      phase_ff        <= phase_in;
      bit_ff          <= bit_in;
      pend_status_ff  <= pend_status_in;
      pend_granted_ff <= pend_granted_in;
      rsp_status_ff   <= rsp_status_in;
      rsp_granted_ff  <= rsp_granted_in;
   end

   // Sequencer.
   always_comb begin
      state_in        = state_ff;
      clr_in          = clr_ff;
      start_in        = start_ff;
      cur_in          = cur_ff;
      phase_in        = phase_ff;
      bit_in          = bit_ff;
      pend_status_in  = pend_status_ff;
      pend_granted_in = pend_granted_ff;
      rsp_valid_in    = rsp_valid_ff && !rsp.ready;
      rsp_status_in   = rsp_status_ff;
      rsp_granted_in  = rsp_granted_ff;
      ram_we          = 1'b0;
      ram_waddr       = cur_ff;
      ram_wdata       = '0;
      ram_re          = 1'b0;
      ram_raddr       = cur_ff;

      unique case (state_ff)
         S_CLEAR: begin
            ram_we    = 1'b1;
            ram_waddr = clr_ff;
            clr_in    = clr_ff + AW'(1);
            if (clr_ff == AW'(WORDS - 1)) begin
               state_in = S_IDLE;
            end
         end

         S_IDLE: begin
            if (req.valid) begin
               pend_granted_in = '0;
               if (req.kind == KIND_ALLOC) begin
                  if (live_n == '0) begin
                     pend_status_in = STATUS_FULL;
                     state_in       = S_DONE;
                  end else if (start_live) begin
                     cur_in    = start_word;
                     phase_in  = 1'b0;
                     ram_re    = 1'b1;
                     ram_raddr = start_word;
                     state_in  = S_SCAN;
                  end else begin
                     cur_in    = '0;
                     phase_in  = 1'b1;
                     ram_re    = 1'b1;
                     ram_raddr = '0;
                     state_in  = S_SCAN;
                  end
               end else begin
                  if (free_live) begin
                     cur_in    = free_slot[XW-1:BIT_W];
                     bit_in    = free_slot[BIT_W-1:0];
                     ram_re    = 1'b1;
                     ram_raddr = free_slot[XW-1:BIT_W];
                     state_in  = S_FREE;
                  end else begin
                     pend_status_in = STATUS_RANGE;
                     state_in       = S_DONE;
                  end
               end
            end
         end

         S_SCAN: begin
            if (hit.found) begin
               ram_we          = 1'b1;
               ram_wdata       = ram_rdata | (WORD_W'(1) << hit.pos);
               start_in        = SW'({cur_ff, hit.pos});
               pend_status_in  = STATUS_DONE;
               pend_granted_in = base_ff + ID_W'({cur_ff, hit.pos});
               state_in        = S_DONE;
            end else if (cur_ff == last_word) begin
               if (!phase_ff) begin
                  // Nothing at or after the search start: wrap to slot zero.
                  cur_in    = '0;
                  phase_in  = 1'b1;
                  ram_re    = 1'b1;
                  ram_raddr = '0;
               end else begin
                  pend_status_in = STATUS_FULL;
                  state_in       = S_DONE;
               end
            end else begin
               cur_in    = cur_ff + AW'(1);
               ram_re    = 1'b1;
               ram_raddr = cur_ff + AW'(1);
            end
         end

         S_FREE: begin
            ram_we          = 1'b1;
            ram_wdata       = ram_rdata & ~(WORD_W'(1) << bit_ff);
            pend_status_in  = STATUS_DONE;
            pend_granted_in = '0;
            state_in        = S_DONE;
         end

         S_DONE: begin
            if (out_free) begin
               rsp_valid_in   = 1'b1;
               rsp_status_in  = pend_status_ff;
               rsp_granted_in = pend_granted_ff;
               state_in       = S_IDLE;
            end
         end

         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // A response other than a successful allocate never carries an identifier.
   a_granted_zero: assert property (@(posedge clock) disable iff (reset)
      rsp.valid && rsp.status != STATUS_DONE |-> rsp.granted_index == '0)
      else $error("failed response carries a granted identifier");

   // The scan never reads a map word beyond the live count.
   a_scan_bound: assert property (@(posedge clock) disable iff (reset)
      state_ff == S_SCAN |-> cur_ff <= last_word)
      else $error("scan pointer beyond the last live word");

   // Only the three defined status codes reach the output.
   a_status_code: assert property (@(posedge clock) disable iff (reset)
      rsp.valid |-> (rsp.status == STATUS_DONE || rsp.status == STATUS_FULL ||
                     rsp.status == STATUS_RANGE))
      else $error("undefined status code on the response");

   // A new response is loaded only from the finishing state.
   a_load_from_done: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(state_ff) == S_DONE)
      else $error("response raised outside the finishing state");

endmodule

`default_nettype wire

[rtl/nfia_ram.sv]
`timescale 1ns / 1ps
`default_nettype none

module nfia_ram #(
   parameter  int WIDTH  = 32,
   parameter  int DEPTH  = 8,
   localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  wire logic              clock,
   input  wire logic              wr_en,
   input  wire logic [ADDR_W-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]  wr_data,
   input  wire logic              rd_en,
   input  wire logic [ADDR_W-1:0] rd_addr,
   output      logic [WIDTH-1:0]  rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data <= mem_ff[rd_addr];
      end
   end

endmodule

`default_nettype wire
